### hw/rtl/net_pkg.sv
// Shared types and constants for the note event tracker.
// Depends on nothing; net_cfg, net_dp, net_ctrl and note_event_tracker import it.
package net_pkg;

  // APB address width: eight 32-bit registers at byte offsets 4*i
  localparam int ADDR_W = 5;

  // Item kinds
  localparam logic [1:0] KIND_STIM = 2'd0;
  localparam logic [1:0] KIND_ON   = 2'd1;
  localparam logic [1:0] KIND_OFF  = 2'd2;

  // Register indexes
  typedef enum logic [2:0] {
    REG_GAP_LIMIT     = 3'd0,
    REG_MIN_DURATION  = 3'd1,
    REG_ATTACK_WINDOW = 3'd2,
    REG_EMIT_LEVEL    = 3'd3,
    REG_STIM_LEVEL    = 3'd4,
    REG_RISE_ABS      = 3'd5,
    REG_RISE_REL      = 3'd6,
    REG_BASE_NOTE     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] gap_limit;
    logic [31:0] min_duration;
    logic [31:0] attack_window;
    logic [15:0] emit_level_min;
    logic [15:0] stimulus_level_min;
    logic [15:0] rise_abs_min;
    logic [15:0] rise_rel_min;
    logic [6:0]  base_note;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic take;         // input ready
    logic ram_re;       // read the entry of the current slot
    logic commit;       // write back the evaluated slot
    logic idx_inc;      // advance the sweep index
    logic load_status;  // load the closing status word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic go_one;       // stimulus for a slot in range
    logic go_sweep;     // turn-on or turn-off sweep
    logic idx_last;
    logic emit;         // evaluated slot produces a note word
    logic out_free;     // output register can take a word
  } sts_t;

endpackage

### hw/rtl/net_if.sv
// Valid/ready channel interfaces for input items and result words.
// Depends on nothing.
interface net_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  slot;
  logic [31:0] now;
  logic [15:0] level;
  logic [31:0] onset_at;

  modport source (output valid, kind, slot, now, level, onset_at, input ready);
  modport sink (input valid, kind, slot, now, level, onset_at, output ready);
endinterface

interface net_out_if;
  logic        valid;
  logic        ready;
  logic        is_note;
  logic [6:0]  note_number;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [15:0] peak_level;
  logic        by_reattack;
  logic [5:0]  voices;
  logic        last;

  modport source (output valid, is_note, note_number, start_time, end_time, peak_level,
                  by_reattack, voices, last, input ready);
  modport sink (input valid, is_note, note_number, start_time, end_time, peak_level,
                by_reattack, voices, last, output ready);
endinterface

### hw/rtl/net_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module net_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 48
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/net_cfg.sv
// APB register file holding the tracker thresholds and base note.
// Depends on net_pkg.
module net_cfg
  import net_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  // Decode writes
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_GAP_LIMIT:     cfg_d.gap_limit          = pwdata;
        REG_MIN_DURATION:  cfg_d.min_duration       = pwdata;
        REG_ATTACK_WINDOW: cfg_d.attack_window      = pwdata;
        REG_EMIT_LEVEL:    cfg_d.emit_level_min     = pwdata[15:0];
        REG_STIM_LEVEL:    cfg_d.stimulus_level_min = pwdata[15:0];
        REG_RISE_ABS:      cfg_d.rise_abs_min       = pwdata[15:0];
        REG_RISE_REL:      cfg_d.rise_rel_min       = pwdata[15:0];
        REG_BASE_NOTE:     cfg_d.base_note          = pwdata[6:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_GAP_LIMIT:     prdata = cfg_q.gap_limit;
      REG_MIN_DURATION:  prdata = cfg_q.min_duration;
      REG_ATTACK_WINDOW: prdata = cfg_q.attack_window;
      REG_EMIT_LEVEL:    prdata = {16'd0, cfg_q.emit_level_min};
      REG_STIM_LEVEL:    prdata = {16'd0, cfg_q.stimulus_level_min};
      REG_RISE_ABS:      prdata = {16'd0, cfg_q.rise_abs_min};
      REG_RISE_REL:      prdata = {16'd0, cfg_q.rise_rel_min};
      REG_BASE_NOTE:     prdata = {25'd0, cfg_q.base_note};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit          <= 32'd50;
      cfg_q.min_duration       <= 32'd50;
      cfg_q.attack_window      <= 32'd50;
      cfg_q.emit_level_min     <= 16'd0;
      cfg_q.stimulus_level_min <= 16'd0;
      cfg_q.rise_abs_min       <= 16'd0;
      cfg_q.rise_rel_min       <= 16'd256;
      cfg_q.base_note          <= 7'd21;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/net_dp.sv
// Datapath: item registers, slot table (flag flops plus entry RAM),
// slot evaluation, voice counter and output register. Depends on net_pkg,
// net_if and net_ram.
module net_dp
  import net_pkg::*;
#(
  parameter int SLOT_COUNT = 48,
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  net_in_if.sink     in_i,
  net_out_if.source  out_o
);

  localparam int TW  = TIME_BITS;
  localparam int LW  = LEVEL_BITS;
  localparam int CW  = (TW > 32) ? TW : 32;
  localparam int LCW = (LW > 16) ? LW : 16;
  localparam int PW  = LW + 16;
  localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int EW  = 2 * TW + 2 * LW;

  typedef struct packed {
    logic [TW-1:0] onset;
    logic [TW-1:0] rtime;
    logic [LW-1:0] peak;
    logic [LW-1:0] rlevel;
  } ent_t;

  // Item registers
  logic [1:0]  kind_q;
  logic [5:0]  slot_q;
  logic [TW-1:0] now_q, at_q;
  logic [LW-1:0] lev_q;
  logic [SW-1:0] idx_q, idx_d;

  // Slot flags: on, evidence, level fields valid
  logic [SLOT_COUNT-1:0] on_q, on_d, ev_q, ev_d, lv_q, lv_d;
  logic [5:0] cnt_q, cnt_d;

  logic accept;
  assign accept   = in_i.valid && cmd_i.take;
  assign in_i.ready = cmd_i.take;

  // Capture the input word and set the starting slot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      slot_q <= in_i.slot;
      now_q  <= TW'(in_i.now);
      lev_q  <= LW'(in_i.level);
      at_q   <= TW'(in_i.onset_at);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = (in_i.kind == KIND_STIM) ? SW'(in_i.slot) : '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Entry RAM
  logic [EW-1:0] rdata;
  ent_t e, nxt;
  logic we;

  net_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && we),
    .waddr_i (idx_q),
    .wdata_i (nxt),
    .re_i    (cmd_i.ram_re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign e = ent_t'(rdata);

  // Evaluate the current slot
  logic on, ev, lv;
  logic [LW-1:0] pk, rl, diff;
  logic [PW-1:0] rel_l, rel_r;
  logic long_en, stim_ok, in_win, rise, loud, turn_on, turn_off;
  logic emit, reatt, set_on, clr_all, set_ev, set_lv, cnt_inc, cnt_dec;

  assign on = on_q[idx_q];
  assign ev = ev_q[idx_q];
  assign lv = lv_q[idx_q];
  assign pk = lv ? e.peak : '0;
  assign rl = lv ? e.rlevel : '0;
  assign diff = lev_q - rl;

  assign long_en = (e.rtime >= e.onset) &&
                   (CW'(e.rtime - e.onset) >= CW'(cfg_i.min_duration));
  assign stim_ok = LCW'(lev_q) >= LCW'(cfg_i.stimulus_level_min);
  assign in_win  = !on || (now_q <= e.onset) ||
                   (CW'(now_q - e.onset) <= CW'(cfg_i.attack_window));
  assign rel_l   = PW'({diff, 8'h00});
  assign rel_r   = PW'(cfg_i.rise_rel_min) * PW'(rl);
  assign rise    = (lev_q > rl) && (LCW'(diff) > LCW'(cfg_i.rise_abs_min)) &&
                   (rel_l > rel_r) && long_en;
  assign loud    = LCW'(pk) >= LCW'(cfg_i.emit_level_min);
  assign turn_on = !on && ev && (e.rtime <= now_q);
  assign turn_off = on && (now_q > e.rtime) &&
                    (CW'(now_q - e.rtime) > CW'(cfg_i.gap_limit));

  always_comb begin
    nxt      = '{onset: e.onset, rtime: e.rtime, peak: pk, rlevel: rl};
    we       = 1'b0;
    emit     = 1'b0;
    reatt    = 1'b0;
    set_on   = 1'b0;
    clr_all  = 1'b0;
    set_ev   = 1'b0;
    set_lv   = 1'b0;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    case (kind_q)
      KIND_STIM: begin
        if (stim_ok) begin
          we         = 1'b1;
          set_lv     = 1'b1;
          nxt.rtime  = now_q;
          nxt.rlevel = lev_q;
          if (in_win) begin
            if (pk < lev_q) begin
              nxt.peak = lev_q;
              set_ev   = 1'b1;
            end
          end else if (rise) begin
            emit      = loud;
            reatt     = 1'b1;
            nxt.onset = now_q;
            nxt.peak  = lev_q;
            set_ev    = 1'b1;
          end
        end
      end
      KIND_ON: begin
        if (turn_on) begin
          we        = 1'b1;
          set_on    = 1'b1;
          nxt.onset = at_q;
          cnt_inc   = 1'b1;
        end
      end
      KIND_OFF: begin
        if (turn_off) begin
          emit    = long_en && loud;
          clr_all = 1'b1;
          cnt_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Flag and voice count updates
  always_comb begin
    on_d  = on_q;
    ev_d  = ev_q;
    lv_d  = lv_q;
    cnt_d = cnt_q;
    if (cmd_i.commit) begin
      if (set_on) on_d[idx_q] = 1'b1;
      if (set_ev) ev_d[idx_q] = 1'b1;
      if (set_lv) lv_d[idx_q] = 1'b1;
      if (clr_all) begin
        on_d[idx_q] = 1'b0;
        ev_d[idx_q] = 1'b0;
        lv_d[idx_q] = 1'b0;
      end
      if (cnt_inc) cnt_d = cnt_q + 6'd1;
      if (cnt_dec && cnt_q != 6'd0) cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q  <= '0;
      ev_q  <= '0;
      lv_q  <= '0;
      cnt_q <= '0;
    end else begin
      on_q  <= on_d;
      ev_q  <= ev_d;
      lv_q  <= lv_d;
      cnt_q <= cnt_d;
    end
  end

  // Output register
  logic out_vq;
  logic out_free, load_note;
  assign out_free  = !out_vq || out_o.ready;
  assign load_note = cmd_i.commit && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (load_note || cmd_i.load_status) begin
      out_vq <= 1'b1;
    end else if (out_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_note) begin
      out_o.is_note     <= 1'b1;
      out_o.note_number <= cfg_i.base_note + 7'(idx_q);
      out_o.start_time  <= 32'(e.onset);
      out_o.end_time    <= 32'(e.rtime);
      out_o.peak_level  <= 16'(pk);
      out_o.by_reattack <= reatt;
      out_o.voices      <= 6'd0;
      out_o.last        <= 1'b0;
    end else if (cmd_i.load_status) begin
      out_o.is_note     <= 1'b0;
      out_o.note_number <= 7'd0;
      out_o.start_time  <= 32'd0;
      out_o.end_time    <= 32'd0;
      out_o.peak_level  <= 16'd0;
      out_o.by_reattack <= 1'b0;
      out_o.voices      <= cnt_q;
      out_o.last        <= 1'b1;
    end
  end

  assign out_o.valid = out_vq;

  // Status to the controller
  assign sts_o.in_valid = in_i.valid;
  assign sts_o.go_one   = (kind_q == KIND_STIM) && ({1'b0, slot_q} < 7'(SLOT_COUNT));
  assign sts_o.go_sweep = (kind_q == KIND_ON) || (kind_q == KIND_OFF);
  assign sts_o.idx_last = (idx_q == SW'(SLOT_COUNT - 1));
  assign sts_o.emit     = emit;
  assign sts_o.out_free = out_free;

  // Voice count tracks the on flags
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(on_q) == int'(cnt_q))
    else $error("voice count differs from on slots");
  a_on_has_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_q & ~ev_q) == '0)
    else $error("slot on without evidence");
  a_ev_has_lv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_q & ~lv_q) == '0)
    else $error("evidence without level fields");
  a_note_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_note |-> (out_free && !cmd_i.load_status))
    else $error("note word loaded over a pending word");

endmodule

### hw/rtl/net_ctrl.sv
// Controller: sequences decode, slot read, evaluation and status per item.
// Depends on net_pkg.
module net_ctrl
  import net_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_EVAL   = 5'b01000,
    S_STATUS = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_valid) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = (sts_i.go_one || sts_i.go_sweep) ? S_READ : S_STATUS;
      end
      S_READ: begin
        cmd_o.ram_re = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        // hold while a note word has no room
        if (!sts_i.emit || sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          if (sts_i.go_sweep && !sts_i.idx_last) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.load_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/note_event_tracker.sv
// Note event tracker: a stimulus item for a slot in range goes from accept through
// decode, slot read and evaluation to the status word; turn-on and turn-off sweeps
// do one entry RAM read and evaluation per slot, and either can stall on the
// output. The next item is accepted the cycle after the status word is loaded.
// Reset clears flag flops and the voice count at once; no clearing pass.
module note_event_tracker
  import net_pkg::*;
#(
  parameter int SLOT_COUNT = 48,
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  net_in_if.sink            in_i,
  net_out_if.source         out_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  net_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  net_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  net_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

endmodule
